// ===== design/rtd_pkg.sv =====
`timescale 1ns / 1ps

package rtd_pkg;

  // Port field widths.
  localparam int AdcRatioW = 16;
  localparam int TempW     = 19;
  localparam int StatusW   = 3;
  localparam int CoefW     = 32;
  localparam int ResW      = 20;
  localparam int CfgIdxW   = 2;

  localparam int AdcBitsDefault = 16;

  // Relative resistance minus one, in units of 2^-24, clamped to 2^40.
  localparam int WIntBits  = 16;
  localparam int WFracBits = 24;
  localparam int WW        = WIntBits + WFracBits + 1;
  localparam logic [WW-1:0] WClamp = {1'b1, {(WW-1){1'b0}}};

  // Discriminant in units of 2^-64 and its root in units of 2^-32.
  localparam int RootW = 38;
  localparam int DiscW = 2 * RootW;

  // Magnitude bits of the temperature quotient before saturation.
  localparam int QuoW = TempW - 1;

  localparam logic signed [TempW-1:0] TempMin = -19'sd51200;
  localparam logic signed [TempW-1:0] TempMax = 19'sd217600;

  // Register reset values.
  localparam logic signed [CoefW-1:0] LinReset     = 32'sd23214298;
  localparam logic signed [CoefW-1:0] QuadReset    = 32'sd7311752;
  localparam logic [ResW-1:0]         SeriesReset  = 20'd2405;
  localparam logic [ResW-1:0]         NominalReset = 20'd1000;

  typedef enum logic [StatusW-1:0] {
    StOk        = 3'd0,
    StFullScale = 3'd1,
    StNoRoot    = 3'd2,
    StBZero     = 3'd3,
    StSaturated = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegLinear    = 2'd0,
    RegQuadratic = 2'd1,
    RegSeries    = 2'd2,
    RegNominal   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoefW-1:0] lin;
    logic signed [CoefW-1:0] quad;
    logic [ResW-1:0]         series;
    logic [ResW-1:0]         nominal;
  } cfg_t;

  // Handoff from the resistance divider to the root stage.
  typedef struct packed {
    status_e       status;
    logic          wneg;
    logic [WW-1:0] w;
  } ratio_t;

  // Handoff from the root stage to the temperature divider.
  typedef struct packed {
    status_e          status;
    logic [RootW-1:0] root;
  } root_t;

endpackage

// ===== design/rtd_in_if.sv =====
`timescale 1ns / 1ps

interface rtd_in_if;
  logic                           valid;
  logic                           ready;
  logic [rtd_pkg::AdcRatioW-1:0] adc_ratio;

  modport source (output valid, output adc_ratio, input ready);
  modport sink (input valid, input adc_ratio, output ready);
endinterface

// ===== design/rtd_out_if.sv =====
`timescale 1ns / 1ps

interface rtd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rtd_pkg::TempW-1:0] temperature;
  logic [rtd_pkg::StatusW-1:0]      status;

  modport source (output valid, output temperature, output status, input ready);
  modport sink (input valid, input temperature, input status, output ready);
endinterface

// ===== design/rtd_cfg_if.sv =====
`timescale 1ns / 1ps

interface rtd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rtd_pkg::CfgIdxW-1:0] index;
  logic [rtd_pkg::CoefW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/rtd_cfg_regs.sv =====
`timescale 1ns / 1ps

module rtd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  rtd_cfg_if.sink       cfg_chan,
  output rtd_pkg::cfg_t cfg_o
);

  rtd_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_chan.ready = 1'b1;
  assign cfg_o          = cfg_q;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lin     <= rtd_pkg::LinReset;
      cfg_q.quad    <= rtd_pkg::QuadReset;
      cfg_q.series  <= rtd_pkg::SeriesReset;
      cfg_q.nominal <= rtd_pkg::NominalReset;
    end else if (cfg_chan.valid) begin
      case (rtd_pkg::cfg_reg_e'(cfg_chan.index))
        rtd_pkg::RegLinear:    cfg_q.lin     <= cfg_chan.data;
        rtd_pkg::RegQuadratic: cfg_q.quad    <= cfg_chan.data;
        rtd_pkg::RegSeries:    cfg_q.series  <= cfg_chan.data[rtd_pkg::ResW-1:0];
        rtd_pkg::RegNominal:   cfg_q.nominal <= cfg_chan.data[rtd_pkg::ResW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rtd_ratio_div.sv =====
`timescale 1ns / 1ps

module rtd_ratio_div #(
  parameter int ADC_BITS = rtd_pkg::AdcBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rtd_pkg::AdcRatioW-1:0] adc_ratio_i,
  input  rtd_pkg::cfg_t                  cfg_i,
  output logic                           valid_o,
  output rtd_pkg::ratio_t                ratio_o
);

  localparam int XW    = rtd_pkg::AdcRatioW;
  localparam int ResW  = rtd_pkg::ResW;
  localparam int SpanW = ADC_BITS + 1;
  localparam int ExtW  = (SpanW > XW + 1) ? SpanW : XW + 1;
  localparam int DenW  = ResW + SpanW;
  localparam int PosW  = ResW + XW;
  localparam int MagW  = (DenW > PosW) ? DenW : PosW;
  localparam int IntW  = rtd_pkg::WIntBits;
  localparam int QuoW  = rtd_pkg::WIntBits + rtd_pkg::WFracBits;
  localparam logic [ExtW-1:0] FullScale = ExtW'(1) << ADC_BITS;

  // Stage A: special cases and the two divider products.
  logic [ExtW-1:0]  x_ext;
  logic [ExtW-1:0]  span_ext;
  logic [SpanW-1:0] span;
  logic [ResW-1:0]  r0;
  rtd_pkg::status_e st_a_d;

  always_comb begin
    x_ext    = ExtW'(adc_ratio_i);
    span_ext = FullScale - x_ext;
    span     = span_ext[SpanW-1:0];
    r0       = (cfg_i.nominal == '0) ? ResW'(1) : cfg_i.nominal;
    if (x_ext >= FullScale) begin
      st_a_d = rtd_pkg::StFullScale;
    end else if (cfg_i.quad == '0) begin
      st_a_d = rtd_pkg::StBZero;
    end else begin
      st_a_d = rtd_pkg::StOk;
    end
  end

  logic             vld_a_q;
  rtd_pkg::status_e st_a_q;
  logic [DenW-1:0]  den_a_q;
  logic [PosW-1:0]  pos_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_a_q  <= st_a_d;
      den_a_q <= r0 * span;
      pos_a_q <= adc_ratio_i * cfg_i.series;
    end
  end

  // Stage B: magnitude and sign of the difference.
  logic [MagW-1:0] pos_ext;
  logic [MagW-1:0] den_ext;
  logic            wneg_d;
  logic [MagW-1:0] mag_d;

  always_comb begin
    pos_ext = MagW'(pos_a_q);
    den_ext = MagW'(den_a_q);
    wneg_d  = pos_ext < den_ext;
    mag_d   = wneg_d ? den_ext - pos_ext : pos_ext - den_ext;
  end

  logic             vld_b_q;
  rtd_pkg::status_e st_b_q;
  logic             wneg_b_q;
  logic [DenW-1:0]  den_b_q;
  logic [MagW-1:0]  mag_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_b_q   <= st_a_q;
      wneg_b_q <= wneg_d;
      den_b_q  <= den_a_q;
      mag_b_q  <= mag_d;
    end
  end

  // Restoring division, one quotient bit per stage. The integer part
  // must stay below 2^16, otherwise the result is clamped.
  typedef struct packed {
    rtd_pkg::status_e status;
    logic             wneg;
    logic             clamp;
    logic [DenW-1:0]  den;
    logic [DenW-1:0]  rem;
    logic [IntW-1:0]  mag_lo;
    logic [QuoW-1:0]  quo;
  } div_t;

  logic [MagW-1:0] mag_hi;
  assign mag_hi = mag_b_q >> IntW;

  div_t div_q   [QuoW];
  logic div_vld_q [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    div_t          prev;
    logic          prev_vld;
    logic          nbit;
    logic [DenW:0] shifted;
    logic [DenW:0] diff;
    logic          ge;
    div_t          nxt;

    if (i == 0) begin : g_head
      always_comb begin
        prev.status = st_b_q;
        prev.wneg   = wneg_b_q;
        prev.clamp  = mag_hi >= MagW'(den_b_q);
        prev.den    = den_b_q;
        prev.rem    = mag_hi[DenW-1:0];
        prev.mag_lo = mag_b_q[IntW-1:0];
        prev.quo    = '0;
      end
      assign prev_vld = vld_b_q;
    end else begin : g_body
      assign prev     = div_q[i-1];
      assign prev_vld = div_vld_q[i-1];
    end

    // Integer bits come from the dividend, fraction bits are zero.
    if (i < IntW) begin : g_bit
      assign nbit = prev.mag_lo[IntW-1-i];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      shifted = {prev.rem, nbit};
      diff    = shifted - {1'b0, prev.den};
      ge      = shifted >= {1'b0, prev.den};
      nxt     = prev;
      nxt.rem = ge ? diff[DenW-1:0] : shifted[DenW-1:0];
      nxt.quo = {prev.quo[QuoW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        div_vld_q[i] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[i] <= nxt;
      end
    end
  end

  assign valid_o        = div_vld_q[QuoW-1];
  assign ratio_o.status = div_q[QuoW-1].status;
  assign ratio_o.wneg   = div_q[QuoW-1].wneg;
  assign ratio_o.w      = div_q[QuoW-1].clamp ? rtd_pkg::WClamp
                                              : {1'b0, div_q[QuoW-1].quo};

endmodule

// ===== design/rtd_root_sqrt.sv =====
`timescale 1ns / 1ps

module rtd_root_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rtd_pkg::ratio_t ratio_i,
  input  rtd_pkg::cfg_t   cfg_i,
  output logic            valid_o,
  output rtd_pkg::root_t  root_o
);

  localparam int CoefW  = rtd_pkg::CoefW;
  localparam int WW     = rtd_pkg::WW;
  localparam int WSplit = 20;
  localparam int PHiW   = CoefW + WW - WSplit;
  localparam int PLoW   = CoefW + WSplit;
  localparam int A2W    = 2 * CoefW;
  localparam int PW     = CoefW + WW + 2;
  localparam int RootW  = rtd_pkg::RootW;
  localparam int DiscW  = rtd_pkg::DiscW;
  localparam int RemW   = RootW + 2;

  // Stage 1: A squared and the two halves of B times W.
  logic [CoefW-1:0] am;
  logic [CoefW-1:0] bm;

  always_comb begin
    am = cfg_i.lin[CoefW-1]  ? unsigned'(-cfg_i.lin)  : unsigned'(cfg_i.lin);
    bm = cfg_i.quad[CoefW-1] ? unsigned'(-cfg_i.quad) : unsigned'(cfg_i.quad);
  end

  logic             vld1_q;
  rtd_pkg::status_e st1_q;
  logic             same1_q;
  logic [A2W-1:0]   a2_1_q;
  logic [PHiW-1:0]  phi1_q;
  logic [PLoW-1:0]  plo1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_q   <= ratio_i.status;
      same1_q <= (cfg_i.quad[CoefW-1] == ratio_i.wneg);
      a2_1_q  <= am * am;
      phi1_q  <= bm * ratio_i.w[WW-1:WSplit];
      plo1_q  <= bm * ratio_i.w[WSplit-1:0];
    end
  end

  // Stage 2: recombine and scale the product by four.
  logic             vld2_q;
  rtd_pkg::status_e st2_q;
  logic             same2_q;
  logic [A2W-1:0]   a2_2_q;
  logic [PW-1:0]    p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st2_q   <= st1_q;
      same2_q <= same1_q;
      a2_2_q  <= a2_1_q;
      p2_q    <= (PW'(phi1_q) << (WSplit + 2)) + (PW'(plo1_q) << 2);
    end
  end

  // Stage 3: discriminant; a negative one has no real root.
  logic [DiscW-1:0] a2_ext;
  logic [DiscW-1:0] p_ext;
  logic             no_root;
  logic [DiscW-1:0] disc_d;
  rtd_pkg::status_e st3_d;

  always_comb begin
    a2_ext  = DiscW'(a2_2_q);
    p_ext   = DiscW'(p2_q);
    no_root = !same2_q && (p_ext > a2_ext);
    disc_d  = same2_q ? a2_ext + p_ext : a2_ext - p_ext;
    st3_d   = (st2_q == rtd_pkg::StOk && no_root) ? rtd_pkg::StNoRoot : st2_q;
  end

  logic             vld3_q;
  rtd_pkg::status_e st3_q;
  logic [DiscW-1:0] disc3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st3_q   <= st3_d;
      disc3_q <= disc_d;
    end
  end

  // Digit-by-digit square root, one root bit per stage.
  typedef struct packed {
    rtd_pkg::status_e status;
    logic [DiscW-1:0] disc;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  sq_t  sq_q   [RootW];
  logic sq_vld_q [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    localparam int PairLo = 2 * (RootW - 1 - j);

    sq_t             prev;
    logic            prev_vld;
    logic [RemW+1:0] shifted;
    logic [RemW+1:0] trial;
    logic [RemW+1:0] diff;
    logic            ge;
    sq_t             nxt;

    if (j == 0) begin : g_head
      always_comb begin
        prev.status = st3_q;
        prev.disc   = disc3_q;
        prev.rem    = '0;
        prev.root   = '0;
      end
      assign prev_vld = vld3_q;
    end else begin : g_body
      assign prev     = sq_q[j-1];
      assign prev_vld = sq_vld_q[j-1];
    end

    always_comb begin
      shifted  = {prev.rem, prev.disc[PairLo+1:PairLo]};
      trial    = {2'b00, prev.root, 2'b01};
      diff     = shifted - trial;
      ge       = shifted >= trial;
      nxt      = prev;
      nxt.rem  = ge ? diff[RemW-1:0] : shifted[RemW-1:0];
      nxt.root = {prev.root[RootW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[j] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[j] <= nxt;
      end
    end
  end

  assign valid_o       = sq_vld_q[RootW-1];
  assign root_o.status = sq_q[RootW-1].status;
  assign root_o.root   = sq_q[RootW-1].root;

endmodule

// ===== design/rtd_temp_div.sv =====
`timescale 1ns / 1ps

module rtd_temp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  rtd_pkg::root_t                    root_i,
  input  rtd_pkg::cfg_t                     cfg_i,
  output logic                              valid_o,
  output logic signed [rtd_pkg::TempW-1:0] temperature_o,
  output rtd_pkg::status_e                  status_o
);

  localparam int CoefW = rtd_pkg::CoefW;
  localparam int RootW = rtd_pkg::RootW;
  localparam int TempW = rtd_pkg::TempW;
  localparam int QW    = rtd_pkg::QuoW;
  localparam int DiffW = RootW + 2;
  localparam int NMagW = DiffW - 1;
  // Scale by 32768, times two for the rounding half.
  localparam int ScaleShift = 16;
  localparam int DW    = NMagW + ScaleShift + 1;
  localparam int DvsW  = CoefW + 1;

  // T1: root minus A.
  logic signed [DiffW-1:0] diff_d;
  assign diff_d = $signed({2'b00, root_i.root}) - DiffW'(cfg_i.lin);

  logic                    vld1_q;
  rtd_pkg::status_e        st1_q;
  logic signed [DiffW-1:0] diff1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_q   <= root_i.status;
      diff1_q <= diff_d;
    end
  end

  // T2: magnitudes and sign of the quotient.
  logic [DiffW-1:0] absd;
  logic [CoefW-1:0] bm;

  always_comb begin
    absd = diff1_q[DiffW-1] ? unsigned'(-diff1_q) : unsigned'(diff1_q);
    bm   = cfg_i.quad[CoefW-1] ? unsigned'(-cfg_i.quad) : unsigned'(cfg_i.quad);
  end

  logic             vld2_q;
  rtd_pkg::status_e st2_q;
  logic             neg2_q;
  logic [NMagW-1:0] nmag2_q;
  logic [CoefW-1:0] bm2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st2_q   <= st1_q;
      neg2_q  <= diff1_q[DiffW-1] ^ cfg_i.quad[CoefW-1];
      nmag2_q <= absd[NMagW-1:0];
      bm2_q   <= bm;
    end
  end

  // T3: rounded dividend n*2^16 + b and divisor 2*b.
  logic             vld3_q;
  rtd_pkg::status_e st3_q;
  logic             neg3_q;
  logic [DW-1:0]    dnd3_q;
  logic [DvsW-1:0]  dvs3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st3_q  <= st2_q;
      neg3_q <= neg2_q;
      dnd3_q <= (DW'(nmag2_q) << ScaleShift) + DW'(bm2_q);
      dvs3_q <= {bm2_q, 1'b0};
    end
  end

  // T4: a quotient of 2^18 or more is out of range anyway.
  logic             vld4_q;
  rtd_pkg::status_e st4_q;
  logic             neg4_q;
  logic             sat4_q;
  logic [DvsW-1:0]  dvs4_q;
  logic [DvsW-1:0]  rem4_q;
  logic [QW-1:0]    dlo4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st4_q  <= st3_q;
      neg4_q <= neg3_q;
      sat4_q <= dnd3_q >= (DW'(dvs3_q) << QW);
      dvs4_q <= dvs3_q;
      rem4_q <= dnd3_q[QW+DvsW-1:QW];
      dlo4_q <= dnd3_q[QW-1:0];
    end
  end

  // Restoring division, one quotient bit per stage.
  typedef struct packed {
    rtd_pkg::status_e status;
    logic             neg;
    logic             sat;
    logic [DvsW-1:0]  dvs;
    logic [DvsW-1:0]  rem;
    logic [QW-1:0]    dlo;
    logic [QW-1:0]    quo;
  } qd_t;

  qd_t  qd_q   [QW];
  logic qd_vld_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    qd_t           prev;
    logic          prev_vld;
    logic [DvsW:0] shifted;
    logic [DvsW:0] diff;
    logic          ge;
    qd_t           nxt;

    if (i == 0) begin : g_head
      always_comb begin
        prev.status = st4_q;
        prev.neg    = neg4_q;
        prev.sat    = sat4_q;
        prev.dvs    = dvs4_q;
        prev.rem    = rem4_q;
        prev.dlo    = dlo4_q;
        prev.quo    = '0;
      end
      assign prev_vld = vld4_q;
    end else begin : g_body
      assign prev     = qd_q[i-1];
      assign prev_vld = qd_vld_q[i-1];
    end

    always_comb begin
      shifted = {prev.rem, prev.dlo[QW-1-i]};
      diff    = shifted - {1'b0, prev.dvs};
      ge      = shifted >= {1'b0, prev.dvs};
      nxt     = prev;
      nxt.rem = ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
      nxt.quo = {prev.quo[QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qd_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        qd_vld_q[i] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[i] <= nxt;
      end
    end
  end

  // Sign, saturation and error cases, then the output register.
  qd_t                     last;
  logic signed [TempW-1:0] tmag;
  logic signed [TempW-1:0] tval;
  logic signed [TempW-1:0] temp_d;
  rtd_pkg::status_e        st_d;

  always_comb begin
    last   = qd_q[QW-1];
    tmag   = $signed({1'b0, last.quo});
    tval   = last.neg ? -tmag : tmag;
    temp_d = tval;
    st_d   = rtd_pkg::StOk;
    if (last.status != rtd_pkg::StOk) begin
      temp_d = '0;
      st_d   = last.status;
    end else if (last.sat) begin
      temp_d = last.neg ? rtd_pkg::TempMin : rtd_pkg::TempMax;
      st_d   = rtd_pkg::StSaturated;
    end else if (tval > rtd_pkg::TempMax) begin
      temp_d = rtd_pkg::TempMax;
      st_d   = rtd_pkg::StSaturated;
    end else if (tval < rtd_pkg::TempMin) begin
      temp_d = rtd_pkg::TempMin;
      st_d   = rtd_pkg::StSaturated;
    end
  end

  logic                    out_vld_q;
  logic signed [TempW-1:0] temp_q;
  rtd_pkg::status_e        st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= qd_vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      temp_q <= temp_d;
      st_q   <= st_d;
    end
  end

  assign valid_o       = out_vld_q;
  assign temperature_o = temp_q;
  assign status_o      = st_q;

endmodule

// ===== design/rtd_divider_ratio_to_temperature.sv =====
`timescale 1ns / 1ps

// Converts RTD divider readings to temperature in 1/256 degree steps by
// solving the quadratic Callendar-Van Dusen equation. The block takes one
// reading per clock cycle while the output register is free or being read.
// Each reading passes through registered stages in order: the resistance
// ratio stages, a divider with one quotient bit per stage, the discriminant
// stages, a square root with one bit per stage, the stages that prepare the
// final division, a divider with one bit per stage and the output register.
// When the output word is not taken the whole pipeline holds and the input
// stops accepting. The user must write coefficients and resistors on the
// configuration channel only while no reading is in flight; the block does
// not enforce this. Writes are always accepted.
module rtd_divider_ratio_to_temperature #(
  parameter int ADC_BITS = rtd_pkg::AdcBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rtd_in_if.sink    in_chan,
  rtd_out_if.source out_chan,
  rtd_cfg_if.sink   cfg_chan
);

  logic             en;
  rtd_pkg::cfg_t    cfg;
  logic             ratio_vld;
  rtd_pkg::ratio_t  ratio;
  logic             root_vld;
  rtd_pkg::root_t   root;
  logic             res_vld;
  rtd_pkg::status_e res_status;

  // The pipeline moves whenever the output register is free or being read.
  assign en            = !res_vld || out_chan.ready;
  assign in_chan.ready = en;
  assign out_chan.valid  = res_vld;
  assign out_chan.status = res_status;

  rtd_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  rtd_ratio_div #(
    .ADC_BITS (ADC_BITS)
  ) u_ratio (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_chan.valid),
    .adc_ratio_i (in_chan.adc_ratio),
    .cfg_i       (cfg),
    .valid_o     (ratio_vld),
    .ratio_o     (ratio)
  );

  rtd_root_sqrt u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ratio_vld),
    .ratio_i (ratio),
    .cfg_i   (cfg),
    .valid_o (root_vld),
    .root_o  (root)
  );

  rtd_temp_div u_temp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (root_vld),
    .root_i        (root),
    .cfg_i         (cfg),
    .valid_o       (res_vld),
    .temperature_o (out_chan.temperature),
    .status_o      (res_status)
  );

endmodule
